@@ hdl/ccs_pkg.sv @@
// ----------------------------------------------------------------------------
// ccs_pkg
// Shared types, widths and constants of the colour blob centroid steering block.
// ----------------------------------------------------------------------------
package ccs_pkg;

    localparam int CH_W    = 8;
    localparam int COL_W   = 12;
    localparam int WID_W   = 13;
    localparam int CNT_W   = 23;
    localparam int SUM_W   = 35;
    localparam int AVG_W   = 12;
    localparam int DIR_W   = 2;
    localparam int CIDX_W  = 3;
    localparam int CDAT_W  = 23;

    localparam logic [WID_W-1:0] MIN_WIDTH        = 13'd3;
    localparam logic [WID_W-1:0] MAX_WIDTH        = 13'd4096;
    localparam logic [CNT_W-1:0] MAX_FRAME_PIXELS = 23'd4194304;

    // floor(x/3) = (x * 21846) >> 16, exact for x up to 8192
    localparam logic [14:0] THIRD_MUL     = 15'd21846;
    localparam logic [15:0] TWO_THIRD_MUL = 16'd43692;
    localparam int          RECIP_SHIFT   = 16;

    // quotient is below 2^AVG_W as every column is below 2^COL_W
    localparam int          DIV_STEPS = AVG_W;
    localparam int          STEP_W    = 4;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;
    localparam int FIFO_CW    = 3;

    localparam logic [CIDX_W-1:0] CFG_FIRST_MAX  = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_SECOND_MIN = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_THIRD_MAX  = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_MIN_COUNT  = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_WIDTH      = 3'd4;

    typedef enum logic [DIR_W-1:0] {
        DIR_STOP    = 2'd0,
        DIR_LEFT    = 2'd1,
        DIR_FORWARD = 2'd2,
        DIR_RIGHT   = 2'd3
    } t_dir;

    typedef struct packed {
        logic [CH_W-1:0]  first_max;
        logic [CH_W-1:0]  second_min;
        logic [CH_W-1:0]  third_max;
        logic [CNT_W-1:0] min_count;
        logic [WID_W-1:0] width;      // already clamped
    } t_cfg;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [SUM_W-1:0] sum;
    } t_frame;

    function automatic logic [WID_W-1:0] clamp_width(input logic [WID_W-1:0] w);
        logic [WID_W-1:0] r;
        r = w;
        if (w < MIN_WIDTH) begin
            r = MIN_WIDTH;
        end else if (w > MAX_WIDTH) begin
            r = MAX_WIDTH;
        end
        return r;
    endfunction

endpackage

@@ hdl/ccs_front.sv @@
// ----------------------------------------------------------------------------
// ccs_front
// Pixel classifier and per-frame accumulator; hands a frame summary on at
// frame end.
// ----------------------------------------------------------------------------
module ccs_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  ccs_pkg::t_cfg              i_cfg,
    input  logic                       i_push,
    output logic                       o_full,
    input  logic [ccs_pkg::CH_W-1:0]   i_first_channel,
    input  logic [ccs_pkg::CH_W-1:0]   i_second_channel,
    input  logic [ccs_pkg::CH_W-1:0]   i_third_channel,
    input  logic                       i_frame_end,
    input  logic                       i_fifo_full,
    output logic                       o_frame_wr,
    output ccs_pkg::t_frame            o_frame
);

    logic [ccs_pkg::COL_W-1:0] r_col;
    logic [ccs_pkg::CNT_W-1:0] r_cnt;
    logic [ccs_pkg::SUM_W-1:0] r_sum;

    logic [ccs_pkg::COL_W-1:0] n_col;
    logic [ccs_pkg::CNT_W-1:0] n_cnt;
    logic [ccs_pkg::SUM_W-1:0] n_sum;

    logic                      w_accept;
    logic                      w_match;
    logic [ccs_pkg::WID_W-1:0] w_col_inc;

    assign o_full   = i_fifo_full;
    assign w_accept = i_push && !i_fifo_full;

    always_comb begin
        w_match = (i_first_channel < i_cfg.first_max)
               && (i_second_channel > i_cfg.second_min)
               && (i_third_channel < i_cfg.third_max);

        w_col_inc = {1'b0, r_col} + ccs_pkg::WID_W'(1);
        n_col     = (w_col_inc >= i_cfg.width) ? '0 : w_col_inc[ccs_pkg::COL_W-1:0];

        // sum cannot reach 2^35-1: at most 2^22 matches of column < 4096
        n_cnt = r_cnt;
        n_sum = r_sum;
        if (w_match && (r_cnt < ccs_pkg::MAX_FRAME_PIXELS)) begin
            n_cnt = r_cnt + ccs_pkg::CNT_W'(1);
            n_sum = r_sum + ccs_pkg::SUM_W'(r_col);
        end
    end

    assign o_frame_wr    = w_accept && i_frame_end;
    assign o_frame.count = n_cnt;
    assign o_frame.sum   = n_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_cnt <= '0;
            r_sum <= '0;
        end else if (w_accept) begin
            if (i_frame_end) begin
                r_col <= '0;
                r_cnt <= '0;
                r_sum <= '0;
            end else begin
                r_col <= n_col;
                r_cnt <= n_cnt;
                r_sum <= n_sum;
            end
        end
    end

endmodule

@@ hdl/ccs_fifo.sv @@
// ----------------------------------------------------------------------------
// ccs_fifo
// Short queue of frame summaries between the accumulator and the divider.
// ----------------------------------------------------------------------------
module ccs_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_wr,
    input  ccs_pkg::t_frame i_wdata,
    output logic            o_full,
    input  logic            i_rd,
    output ccs_pkg::t_frame o_rdata,
    output logic            o_empty
);

    ccs_pkg::t_frame r_mem [ccs_pkg::FIFO_DEPTH];

    logic [ccs_pkg::FIFO_AW-1:0] r_wr_ptr;
    logic [ccs_pkg::FIFO_AW-1:0] r_rd_ptr;
    logic [ccs_pkg::FIFO_CW-1:0] r_count;

    logic w_wr;
    logic w_rd;

    assign o_full  = (r_count == ccs_pkg::FIFO_CW'(ccs_pkg::FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign w_wr    = i_wr && !o_full;
    assign w_rd    = i_rd && !o_empty;
    assign o_rdata = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_wr) begin
                r_wr_ptr <= r_wr_ptr + ccs_pkg::FIFO_AW'(1);
            end
            if (w_rd) begin
                r_rd_ptr <= r_rd_ptr + ccs_pkg::FIFO_AW'(1);
            end
            unique case ({w_wr, w_rd})
                2'b10:   r_count <= r_count + ccs_pkg::FIFO_CW'(1);
                2'b01:   r_count <= r_count - ccs_pkg::FIFO_CW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    // the front must never offer a summary into a full queue: it would be lost
    a_no_write_when_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr |-> !o_full)
        else $error("frame summary written into full queue");

endmodule

@@ hdl/ccs_back.sv @@
// ----------------------------------------------------------------------------
// ccs_back
// Per-frame mean column by restoring division, steering decision and
// result register.
// ----------------------------------------------------------------------------
module ccs_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  ccs_pkg::t_cfg              i_cfg,
    input  logic                       i_fifo_empty,
    input  ccs_pkg::t_frame            i_frame,
    output logic                       o_fifo_rd,
    output logic                       o_empty,
    input  logic                       i_pop,
    output logic [ccs_pkg::DIR_W-1:0]  o_direction,
    output logic [ccs_pkg::CNT_W-1:0]  o_match_count,
    output logic [ccs_pkg::AVG_W-1:0]  o_average_column
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_DONE
    } t_state;

    t_state                     r_state;
    logic [ccs_pkg::SUM_W-1:0]  r_rem;
    logic [ccs_pkg::SUM_W-1:0]  r_den;
    logic [ccs_pkg::CNT_W-1:0]  r_cnt;
    logic [ccs_pkg::AVG_W-1:0]  r_quo;
    logic [ccs_pkg::STEP_W-1:0] r_step;
    logic                       r_out_valid;
    ccs_pkg::t_dir              r_dir;
    logic [ccs_pkg::CNT_W-1:0]  r_out_cnt;
    logic [ccs_pkg::AVG_W-1:0]  r_avg;
    logic [ccs_pkg::AVG_W-1:0]  r_third;
    logic [ccs_pkg::AVG_W-1:0]  r_two_third;

    logic [27:0]               w_third_prod;
    logic [28:0]               w_two_third_prod;
    logic                      w_ge;
    logic                      w_stop;
    logic                      w_load;
    ccs_pkg::t_dir             w_dir;

    // the user must change width only while idle (the block itself does not enforce it),
    // so the registered thirds are settled long before a frame reaches the decision
    assign w_third_prod     = 28'(i_cfg.width) * 28'(ccs_pkg::THIRD_MUL);
    assign w_two_third_prod = 29'(i_cfg.width) * 29'(ccs_pkg::TWO_THIRD_MUL);

    always_ff @(posedge i_clk) begin
        r_third     <= w_third_prod[ccs_pkg::RECIP_SHIFT +: ccs_pkg::AVG_W];
        r_two_third <= w_two_third_prod[ccs_pkg::RECIP_SHIFT +: ccs_pkg::AVG_W];
    end

    assign w_ge      = (r_rem >= r_den);
    assign w_stop    = (r_cnt <= i_cfg.min_count);
    assign o_fifo_rd = (r_state == S_IDLE) && !i_fifo_empty;
    // result slot takes a new beat when free or emptied by this pop
    assign w_load    = (r_state == S_DONE) && (!r_out_valid || i_pop);

    always_comb begin
        priority if (w_stop) begin
            w_dir = ccs_pkg::DIR_STOP;
        end else if (r_quo <= r_third) begin
            w_dir = ccs_pkg::DIR_LEFT;
        end else if (r_quo >= r_two_third) begin
            w_dir = ccs_pkg::DIR_RIGHT;
        end else begin
            w_dir = ccs_pkg::DIR_FORWARD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (!i_fifo_empty) begin
                        r_rem   <= i_frame.sum;
                        r_den   <= ccs_pkg::SUM_W'({i_frame.count,
                                                    (ccs_pkg::DIV_STEPS-1)'(0)});
                        r_cnt   <= i_frame.count;
                        r_quo   <= '0;
                        r_step  <= ccs_pkg::STEP_W'(ccs_pkg::DIV_STEPS - 1);
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (w_ge) begin
                        r_rem <= r_rem - r_den;
                    end
                    r_quo <= {r_quo[ccs_pkg::AVG_W-2:0], w_ge};
                    r_den <= r_den >> 1;
                    if (r_step == '0) begin
                        r_state <= S_DONE;
                    end else begin
                        r_step <= r_step - ccs_pkg::STEP_W'(1);
                    end
                end
                S_DONE: begin
                    if (w_load) begin
                        r_dir       <= w_dir;
                        r_out_cnt   <= r_cnt;
                        r_avg       <= w_stop ? '0 : r_quo;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_empty          = !r_out_valid;
    assign o_direction      = r_dir;
    assign o_match_count    = r_out_cnt;
    assign o_average_column = r_avg;

    // restoring division keeps the partial remainder below twice the shifted divisor
    a_rem_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && r_cnt != '0) |-> (r_rem < {r_den[ccs_pkg::SUM_W-2:0], 1'b0}))
        else $error("divider remainder out of range");

    a_load_from_done : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_DONE))
        else $error("result loaded outside decision state");

    a_stop_zero_avg : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_dir == ccs_pkg::DIR_STOP) |-> (r_avg == '0))
        else $error("stop result with non-zero mean column");

endmodule

@@ hdl/color_blob_centroid_steering.sv @@
// Flow: a frame's summary is queued at its last pixel beat, then dequeued, run through
//   12 divider steps and decided; the result is registered once the result slot is free.
// Throughput: one pixel per cycle while the summary queue is not full; the back end
//   takes one frame at a time, so a run of short frames fills the 4-entry queue and asserts full.
// Reset: synchronous, active low; clears accumulators, queue and result slot and
//   loads the register defaults (90, 100, 120, 20, 640).
// ----------------------------------------------------------------------------
// color_blob_centroid_steering
// Colour-threshold blob tracker giving one steering code per frame.
// ----------------------------------------------------------------------------
module color_blob_centroid_steering (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic [ccs_pkg::CH_W-1:0]    i_first_channel,
    input  logic [ccs_pkg::CH_W-1:0]    i_second_channel,
    input  logic [ccs_pkg::CH_W-1:0]    i_third_channel,
    input  logic                        i_frame_end,
    output logic                        empty,
    input  logic                        pop,
    output logic [ccs_pkg::DIR_W-1:0]   o_direction,
    output logic [ccs_pkg::CNT_W-1:0]   o_match_count,
    output logic [ccs_pkg::AVG_W-1:0]   o_average_column,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [ccs_pkg::CIDX_W-1:0]  i_cfg_index,
    input  logic [ccs_pkg::CDAT_W-1:0]  i_cfg_data
);

    logic [ccs_pkg::CH_W-1:0]  r_first_max;
    logic [ccs_pkg::CH_W-1:0]  r_second_min;
    logic [ccs_pkg::CH_W-1:0]  r_third_max;
    logic [ccs_pkg::CNT_W-1:0] r_min_count;
    logic [ccs_pkg::WID_W-1:0] r_width;

    ccs_pkg::t_cfg   w_cfg;
    ccs_pkg::t_frame w_wr_frame;
    ccs_pkg::t_frame w_rd_frame;
    logic            w_frame_wr;
    logic            w_fifo_full;
    logic            w_fifo_rd;
    logic            w_fifo_empty;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first_max  <= 8'd90;
            r_second_min <= 8'd100;
            r_third_max  <= 8'd120;
            r_min_count  <= 23'd20;
            r_width      <= 13'd640;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                ccs_pkg::CFG_FIRST_MAX:  r_first_max  <= i_cfg_data[ccs_pkg::CH_W-1:0];
                ccs_pkg::CFG_SECOND_MIN: r_second_min <= i_cfg_data[ccs_pkg::CH_W-1:0];
                ccs_pkg::CFG_THIRD_MAX:  r_third_max  <= i_cfg_data[ccs_pkg::CH_W-1:0];
                ccs_pkg::CFG_MIN_COUNT:  r_min_count  <= i_cfg_data[ccs_pkg::CNT_W-1:0];
                ccs_pkg::CFG_WIDTH:      r_width      <= i_cfg_data[ccs_pkg::WID_W-1:0];
                default: ;
            endcase
        end
    end

    assign w_cfg.first_max  = r_first_max;
    assign w_cfg.second_min = r_second_min;
    assign w_cfg.third_max  = r_third_max;
    assign w_cfg.min_count  = r_min_count;
    assign w_cfg.width      = ccs_pkg::clamp_width(r_width);

    ccs_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (w_cfg),
        .i_push           (push),
        .o_full           (full),
        .i_first_channel  (i_first_channel),
        .i_second_channel (i_second_channel),
        .i_third_channel  (i_third_channel),
        .i_frame_end      (i_frame_end),
        .i_fifo_full      (w_fifo_full),
        .o_frame_wr       (w_frame_wr),
        .o_frame          (w_wr_frame)
    );

    ccs_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_frame_wr),
        .i_wdata (w_wr_frame),
        .o_full  (w_fifo_full),
        .i_rd    (w_fifo_rd),
        .o_rdata (w_rd_frame),
        .o_empty (w_fifo_empty)
    );

    ccs_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg            (w_cfg),
        .i_fifo_empty     (w_fifo_empty),
        .i_frame          (w_rd_frame),
        .o_fifo_rd        (w_fifo_rd),
        .o_empty          (empty),
        .i_pop            (pop),
        .o_direction      (o_direction),
        .o_match_count    (o_match_count),
        .o_average_column (o_average_column)
    );

endmodule
